/* rtl/core/rcra_pkg.sv */
package rcra_pkg;

    localparam int FRAC_BITS_DEF = 16;

    // operand, product and wide sum widths
    localparam int OP_W   = 33;
    localparam int PROD_W = 2 * OP_W;
    localparam int SUM_W  = PROD_W + 3;
    localparam int ACC_W  = 48;

    typedef enum logic [1:0] {
        KIND_ROT   = 2'd0,
        KIND_SHIFT = 2'd1,
        KIND_POINT = 2'd2,
        KIND_NONE  = 2'd3
    } in_kind_t;

    typedef enum logic [1:0] {
        RK_RESIDUAL = 2'd0,
        RK_STIFF    = 2'd1,
        RK_FORCE    = 2'd2,
        RK_MOMENT   = 2'd3
    } res_kind_t;

    // element of the cross-product matrix of v, row major
    function automatic logic signed [OP_W-1:0] skew_elem(
        input logic signed [31:0] v0,
        input logic signed [31:0] v1,
        input logic signed [31:0] v2,
        input logic [3:0]         idx
    );
        logic signed [OP_W-1:0] e0;
        logic signed [OP_W-1:0] e1;
        logic signed [OP_W-1:0] e2;
        logic signed [OP_W-1:0] r;
        e0 = OP_W'(v0);
        e1 = OP_W'(v1);
        e2 = OP_W'(v2);
        case (idx)
            4'd1:    r = -e2;
            4'd2:    r = e1;
            4'd3:    r = e2;
            4'd5:    r = -e0;
            4'd6:    r = -e1;
            4'd7:    r = e0;
            default: r = '0;
        endcase
        return r;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [SUM_W:0] v);
        logic signed [31:0] r;
        if (v > SUM_W'(33'sd2147483647))
            r = 32'sh7fffffff;
        else if (v < -(SUM_W'(33'sd2147483648)))
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

    function automatic logic signed [ACC_W-1:0] sat48(input logic signed [SUM_W:0] v);
        logic signed [ACC_W-1:0] r;
        if (v > ((SUM_W+1)'(1) <<< (ACC_W-1)) - 1)
            r = {1'b0, {(ACC_W-1){1'b1}}};
        else if (v < -((SUM_W+1)'(1) <<< (ACC_W-1)))
            r = {1'b1, {(ACC_W-1){1'b0}}};
        else
            r = v[ACC_W-1:0];
        return r;
    endfunction

endpackage

/* rtl/core/rigid_contact_residual_assembly_core.sv */
// rigid contact residual and stiffness assembly
//
// input channel (in_valid / in_stall): a kind 0 word loads one row of the
// rotation matrix, a kind 1 word loads the rigid translation; both finish in
// the cycle they are accepted and give no result. a kind 2 word is a contact
// point: the block rotates the arm, builds the residual and subtracts from the
// stiffness, force and moment sums using one shared 33x33 multiplier.
// each of the 45 products passes a multiply state and then an accumulate
// state, and the residual word of a point is offered once all 45 are summed.
// output channel (out_valid / out_stall): one residual word per point; on a
// point marked final it is followed by three stiffness rows, the force sum
// and the moment sum, after which the sums are cleared. each result word
// is loaded into the output register and held until it is taken; a stalled
// word holds and the input stays stalled until the last word is taken.
// reset: rotation is identity, translation and all sums are zero.
module rigid_contact_residual_assembly_core
    import rcra_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         kind,
    input  logic [1:0]         row_index,
    input  logic signed [31:0] vec_a_x,
    input  logic signed [31:0] vec_a_y,
    input  logic signed [31:0] vec_a_z,
    input  logic signed [31:0] mult_x,
    input  logic signed [31:0] mult_y,
    input  logic signed [31:0] mult_z,
    input  logic signed [31:0] node_x,
    input  logic signed [31:0] node_y,
    input  logic signed [31:0] node_z,
    input  logic               final_point,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [1:0]         result_kind,
    output logic [1:0]         result_row,
    output logic signed [31:0] out_x,
    output logic signed [31:0] out_y,
    output logic signed [31:0] out_z,
    output logic               end_of_run
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_ACC,
        ST_EMIT
    } state_t;

    typedef enum logic [1:0] {
        PH_ROT,
        PH_STIFF,
        PH_MOMENT
    } phase_t;

    state_t state_reg;
    phase_t phase_reg;
    logic [1:0] i_reg, j_reg, k_reg;
    logic [2:0] e_reg;

    logic signed [31:0]      rot_reg [0:8];
    logic signed [31:0]      shift_reg [0:2];
    logic signed [ACC_W-1:0] stiff_reg [0:8];
    logic signed [ACC_W-1:0] force_reg [0:2];
    logic signed [ACC_W-1:0] moment_reg [0:2];

    logic signed [31:0] a_reg [0:2];
    logic signed [31:0] lam_reg [0:2];
    logic signed [31:0] nd_reg [0:2];
    logic signed [31:0] b_reg [0:2];
    logic               final_reg;
    logic signed [SUM_W-1:0] s_reg;

    logic               out_valid_reg;
    logic [1:0]         rkind_reg, rrow_reg;
    logic signed [31:0] ox_reg, oy_reg, oz_reg;
    logic               eor_reg;

    logic signed [OP_W-1:0]   opa, opb;
    logic signed [PROD_W-1:0] prod;
    logic [3:0] idx_ij, idx_ik, idx_kj;
    logic       first_term, last_term;
    logic signed [SUM_W-1:0] s_next;
    logic in_take;

    assign in_take = in_valid && !in_stall;
    assign idx_ij  = 4'(i_reg) * 4'd3 + 4'(j_reg);
    assign idx_ik  = 4'(i_reg) * 4'd3 + 4'(k_reg);
    assign idx_kj  = 4'(k_reg) * 4'd3 + 4'(j_reg);

    // operand selection for the shared multiplier
    always_comb
    begin
        case (phase_reg)
            PH_ROT:
            begin
                opa = OP_W'(rot_reg[idx_ij]);
                opb = OP_W'(a_reg[j_reg]);
                first_term = (j_reg == 2'd0);
                last_term  = (j_reg == 2'd2);
            end
            PH_STIFF:
            begin
                opa = skew_elem(lam_reg[0], lam_reg[1], lam_reg[2], idx_ik);
                opb = skew_elem(b_reg[0], b_reg[1], b_reg[2], idx_kj);
                first_term = (k_reg == 2'd0);
                last_term  = (k_reg == 2'd2);
            end
            default:
            begin
                opa = skew_elem(b_reg[0], b_reg[1], b_reg[2], idx_ij);
                opb = OP_W'(lam_reg[j_reg]);
                first_term = (j_reg == 2'd0);
                last_term  = (j_reg == 2'd2);
            end
        endcase
    end

    rcra_mul #(
        .FRAC_BITS (FRAC_BITS)
    ) u_mul (
        .clk  (clk),
        .opa  (opa),
        .opb  (opb),
        .prod (prod)
    );

    // running sum of the current term group
    assign s_next = (first_term ? SUM_W'(0) : s_reg) + SUM_W'(prod);

    // sequencer, state and result word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            phase_reg     <= PH_ROT;
            i_reg         <= '0;
            j_reg         <= '0;
            k_reg         <= '0;
            e_reg         <= '0;
            out_valid_reg <= 1'b0;
            for (int n = 0; n < 9; n++)
            begin
                rot_reg[n]   <= (n % 4 == 0) ? (32'sd1 <<< FRAC_BITS) : 32'sd0;
                stiff_reg[n] <= '0;
            end
            for (int n = 0; n < 3; n++)
            begin
                shift_reg[n]  <= '0;
                force_reg[n]  <= '0;
                moment_reg[n] <= '0;
            end
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_take)
                    begin
                        case (kind)
                            KIND_ROT:
                            begin
                                if (row_index != 2'd3)
                                begin
                                    rot_reg[4'(row_index) * 4'd3]        <= vec_a_x;
                                    rot_reg[4'(row_index) * 4'd3 + 4'd1] <= vec_a_y;
                                    rot_reg[4'(row_index) * 4'd3 + 4'd2] <= vec_a_z;
                                end
                            end
                            KIND_SHIFT:
                            begin
                                shift_reg[0] <= vec_a_x;
                                shift_reg[1] <= vec_a_y;
                                shift_reg[2] <= vec_a_z;
                            end
                            KIND_POINT:
                            begin
                                a_reg[0]   <= vec_a_x;
                                a_reg[1]   <= vec_a_y;
                                a_reg[2]   <= vec_a_z;
                                lam_reg[0] <= mult_x;
                                lam_reg[1] <= mult_y;
                                lam_reg[2] <= mult_z;
                                nd_reg[0]  <= node_x;
                                nd_reg[1]  <= node_y;
                                nd_reg[2]  <= node_z;
                                final_reg  <= final_point;
                                phase_reg  <= PH_ROT;
                                i_reg      <= '0;
                                j_reg      <= '0;
                                k_reg      <= '0;
                                state_reg  <= ST_MUL;
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
                ST_MUL:
                begin
                    state_reg <= ST_ACC;
                end
                ST_ACC:
                begin
                    s_reg     <= s_next;
                    state_reg <= ST_MUL;
                    case (phase_reg)
                        PH_ROT:
                        begin
                            j_reg <= j_reg + 2'd1;
                            if (last_term)
                            begin
                                b_reg[i_reg] <= sat32((SUM_W+1)'(s_next));
                                j_reg <= '0;
                                i_reg <= i_reg + 2'd1;
                                if (i_reg == 2'd2)
                                begin
                                    i_reg     <= '0;
                                    phase_reg <= PH_STIFF;
                                end
                            end
                        end
                        PH_STIFF:
                        begin
                            k_reg <= k_reg + 2'd1;
                            if (last_term)
                            begin
                                stiff_reg[idx_ij] <= sat48((SUM_W+1)'(stiff_reg[idx_ij])
                                                           - (SUM_W+1)'(s_next));
                                k_reg <= '0;
                                j_reg <= j_reg + 2'd1;
                                if (j_reg == 2'd2)
                                begin
                                    j_reg <= '0;
                                    i_reg <= i_reg + 2'd1;
                                    if (i_reg == 2'd2)
                                    begin
                                        i_reg     <= '0;
                                        phase_reg <= PH_MOMENT;
                                    end
                                end
                            end
                        end
                        default:
                        begin
                            j_reg <= j_reg + 2'd1;
                            if (last_term)
                            begin
                                moment_reg[i_reg] <= sat48((SUM_W+1)'(moment_reg[i_reg])
                                                           - (SUM_W+1)'(s_next));
                                force_reg[i_reg]  <= sat48((SUM_W+1)'(force_reg[i_reg])
                                                           - (SUM_W+1)'(lam_reg[i_reg]));
                                j_reg <= '0;
                                i_reg <= i_reg + 2'd1;
                                if (i_reg == 2'd2)
                                begin
                                    i_reg     <= '0;
                                    phase_reg <= PH_ROT;
                                    e_reg     <= '0;
                                    state_reg <= ST_EMIT;
                                end
                            end
                        end
                    endcase
                end
                ST_EMIT:
                begin
                    if (!out_valid_reg)
                    begin
                        // load the next result word
                        out_valid_reg <= 1'b1;
                        eor_reg  <= (e_reg == 3'd5) || (e_reg == 3'd0 && !final_reg);
                        rrow_reg <= 2'd0;
                        case (e_reg)
                            3'd0:
                            begin
                                rkind_reg <= RK_RESIDUAL;
                                ox_reg <= sat32((SUM_W+1)'(nd_reg[0]) - (SUM_W+1)'(shift_reg[0])
                                                + (SUM_W+1)'(a_reg[0]) - (SUM_W+1)'(b_reg[0]));
                                oy_reg <= sat32((SUM_W+1)'(nd_reg[1]) - (SUM_W+1)'(shift_reg[1])
                                                + (SUM_W+1)'(a_reg[1]) - (SUM_W+1)'(b_reg[1]));
                                oz_reg <= sat32((SUM_W+1)'(nd_reg[2]) - (SUM_W+1)'(shift_reg[2])
                                                + (SUM_W+1)'(a_reg[2]) - (SUM_W+1)'(b_reg[2]));
                            end
                            3'd1, 3'd2, 3'd3:
                            begin
                                rkind_reg <= RK_STIFF;
                                rrow_reg  <= 2'(e_reg - 3'd1);
                                ox_reg <= sat32((SUM_W+1)'(stiff_reg[4'(e_reg - 3'd1) * 4'd3]));
                                oy_reg <= sat32((SUM_W+1)'(
                                    stiff_reg[4'(e_reg - 3'd1) * 4'd3 + 4'd1]));
                                oz_reg <= sat32((SUM_W+1)'(
                                    stiff_reg[4'(e_reg - 3'd1) * 4'd3 + 4'd2]));
                            end
                            3'd4:
                            begin
                                rkind_reg <= RK_FORCE;
                                ox_reg <= sat32((SUM_W+1)'(force_reg[0]));
                                oy_reg <= sat32((SUM_W+1)'(force_reg[1]));
                                oz_reg <= sat32((SUM_W+1)'(force_reg[2]));
                            end
                            default:
                            begin
                                rkind_reg <= RK_MOMENT;
                                ox_reg <= sat32((SUM_W+1)'(moment_reg[0]));
                                oy_reg <= sat32((SUM_W+1)'(moment_reg[1]));
                                oz_reg <= sat32((SUM_W+1)'(moment_reg[2]));
                            end
                        endcase
                    end
                    else if (!out_stall)
                    begin
                        out_valid_reg <= 1'b0;
                        e_reg <= e_reg + 3'd1;
                        if (eor_reg)
                        begin
                            state_reg <= ST_IDLE;
                            if (final_reg)
                            begin
                                for (int n = 0; n < 9; n++)
                                    stiff_reg[n] <= '0;
                                for (int n = 0; n < 3; n++)
                                begin
                                    force_reg[n]  <= '0;
                                    moment_reg[n] <= '0;
                                end
                            end
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign in_stall    = (state_reg != ST_IDLE);
    assign out_valid   = out_valid_reg;
    assign result_kind = rkind_reg;
    assign result_row  = rrow_reg;
    assign out_x       = ox_reg;
    assign out_y       = oy_reg;
    assign out_z       = oz_reg;
    assign end_of_run  = eor_reg;

    // no input taken while a result word is pending
    assert property (@(posedge clk) disable iff (!rst_n) out_valid |-> in_stall)
        else $error("input accepted while result pending");

    // a contact point always occupies the block
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && kind == KIND_POINT) |=> in_stall)
        else $error("contact point did not start the sequencer");

    // sums are cleared once the moment word of a final point is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && result_kind == RK_MOMENT)
        |=> (force_reg[0] == '0 && moment_reg[2] == '0 && stiff_reg[8] == '0))
        else $error("sums not cleared after final point");

    // a residual word ends the run exactly when the point was not final
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && result_kind == RK_RESIDUAL) |-> (end_of_run == !final_reg))
        else $error("residual end flag wrong");

endmodule

/* rtl/core/rcra_mul.sv */
module rcra_mul
    import rcra_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic                     clk,
    input  logic signed [OP_W-1:0]   opa,
    input  logic signed [OP_W-1:0]   opb,
    output logic signed [PROD_W-1:0] prod
);

    logic signed [PROD_W-1:0] prod_reg;

    // exact product, floor rounded by the fraction width
    always_ff @(posedge clk)
    begin
        prod_reg <= (opa * opb) >>> FRAC_BITS;
    end

    assign prod = prod_reg;

endmodule

/* tb/sv/tb.sv */
module tb;
    import rcra_pkg::*;

    localparam int FB = FRAC_BITS_DEF;
    localparam longint ACC_HI = (64'sd1 <<< 47) - 1;
    localparam longint ACC_LO = -(64'sd1 <<< 47);
    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic [1:0]  rk;
        logic [1:0]  row;
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic        last;
    } result_word_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    logic [1:0] kind;
    logic [1:0] row_index;
    logic signed [31:0] vec_a_x, vec_a_y, vec_a_z;
    logic signed [31:0] mult_x, mult_y, mult_z;
    logic signed [31:0] node_x, node_y, node_z;
    logic final_point;
    logic out_valid;
    logic out_stall;
    logic [1:0] result_kind;
    logic [1:0] result_row;
    logic signed [31:0] out_x, out_y, out_z;
    logic end_of_run;

    rigid_contact_residual_assembly_core dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .kind(kind), .row_index(row_index),
        .vec_a_x(vec_a_x), .vec_a_y(vec_a_y), .vec_a_z(vec_a_z),
        .mult_x(mult_x), .mult_y(mult_y), .mult_z(mult_z),
        .node_x(node_x), .node_y(node_y), .node_z(node_z),
        .final_point(final_point),
        .out_valid(out_valid), .out_stall(out_stall),
        .result_kind(result_kind), .result_row(result_row),
        .out_x(out_x), .out_y(out_y), .out_z(out_z),
        .end_of_run(end_of_run)
    );

    // shadow state of the block
    longint rot_m[9];
    longint shift_v[3];
    longint stiff_sum[9];
    longint force_sum[3];
    longint moment_sum[3];

    result_word_t expected_words[$];
    int  failures;
    int  cycles;
    int  stall_left;
    bit  quiet;

    // clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic longint clip32(longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint clip48(longint v);
        if (v > ACC_HI)
            return ACC_HI;
        if (v < ACC_LO)
            return ACC_LO;
        return v;
    endfunction

    // product rounded toward minus infinity
    function automatic longint qmul(longint a, longint b);
        longint p;
        p = a * b;
        return p >>> FB;
    endfunction

    function automatic void cross_mat(output longint m[9], input longint v[3]);
        m[0] = 0;     m[1] = -v[2]; m[2] = v[1];
        m[3] = v[2];  m[4] = 0;     m[5] = -v[0];
        m[6] = -v[1]; m[7] = v[0];  m[8] = 0;
    endfunction

    function automatic result_word_t mk_word(logic [1:0] rk, logic [1:0] row,
                                             longint x, longint y, longint z,
                                             logic last);
        result_word_t w;
        w.rk = rk;
        w.row = row;
        w.x = 32'(clip32(x));
        w.y = 32'(clip32(y));
        w.z = 32'(clip32(z));
        w.last = last;
        return w;
    endfunction

    // predict the result words of one accepted input word
    function automatic void predict_contact(logic [1:0] k, logic [1:0] r,
                                            logic signed [31:0] a[3],
                                            logic signed [31:0] lam_in[3],
                                            logic signed [31:0] nd[3], logic fin);
        longint arm[3], lam[3], b[3], res[3], sl[9], sb[9];
        longint s, q;
        if (k == KIND_ROT)
        begin
            if (r < 3)
                for (int j = 0; j < 3; j++)
                    rot_m[r*3+j] = a[j];
            return;
        end
        if (k == KIND_SHIFT)
        begin
            for (int j = 0; j < 3; j++)
                shift_v[j] = a[j];
            return;
        end
        if (k != KIND_POINT)
            return;
        for (int i = 0; i < 3; i++)
        begin
            arm[i] = a[i];
            lam[i] = lam_in[i];
        end
        for (int i = 0; i < 3; i++)
        begin
            s = 0;
            for (int j = 0; j < 3; j++)
                s += qmul(rot_m[i*3+j], arm[j]);
            b[i] = clip32(s);
            res[i] = longint'(nd[i]) - shift_v[i] + arm[i] - b[i];
        end
        cross_mat(sl, lam);
        cross_mat(sb, b);
        for (int i = 0; i < 3; i++)
        begin
            q = 0;
            for (int j = 0; j < 3; j++)
            begin
                s = 0;
                for (int m = 0; m < 3; m++)
                    s += qmul(sl[i*3+m], sb[m*3+j]);
                stiff_sum[i*3+j] = clip48(stiff_sum[i*3+j] - s);
                q += qmul(sb[i*3+j], lam[j]);
            end
            moment_sum[i] = clip48(moment_sum[i] - q);
            force_sum[i] = clip48(force_sum[i] - lam[i]);
        end
        expected_words.push_back(mk_word(RK_RESIDUAL, 0, res[0], res[1], res[2], !fin));
        if (!fin)
            return;
        for (int i = 0; i < 3; i++)
            expected_words.push_back(mk_word(RK_STIFF, 2'(i), stiff_sum[i*3],
                                             stiff_sum[i*3+1], stiff_sum[i*3+2], 0));
        expected_words.push_back(mk_word(RK_FORCE, 0, force_sum[0], force_sum[1],
                                         force_sum[2], 0));
        expected_words.push_back(mk_word(RK_MOMENT, 0, moment_sum[0], moment_sum[1],
                                         moment_sum[2], 1));
        for (int i = 0; i < 9; i++)
            stiff_sum[i] = 0;
        for (int i = 0; i < 3; i++)
        begin
            force_sum[i] = 0;
            moment_sum[i] = 0;
        end
    endfunction

    // send one word, with an optional idle burst first
    task automatic send_word(logic [1:0] k, logic [1:0] r,
                             logic signed [31:0] a[3], logic signed [31:0] lam[3],
                             logic signed [31:0] nd[3], logic fin);
        int gap;
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 5);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        kind <= k;
        row_index <= r;
        vec_a_x <= a[0]; vec_a_y <= a[1]; vec_a_z <= a[2];
        mult_x <= lam[0]; mult_y <= lam[1]; mult_z <= lam[2];
        node_x <= nd[0]; node_y <= nd[1]; node_z <= nd[2];
        final_point <= fin;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_contact(k, r, a, lam, nd, fin);
    endtask

    function automatic logic signed [31:0] rnd_val();
        case ($urandom_range(0, 7))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            2: return 32'sd0;
            3, 4: return 32'($signed($urandom_range(0, 32'h3ffff)) - 32'sh20000);
            default: return $urandom;
        endcase
    endfunction

    task automatic send_random(logic [1:0] k, logic [1:0] r, logic fin);
        logic signed [31:0] a[3], lam[3], nd[3];
        for (int i = 0; i < 3; i++)
        begin
            a[i] = rnd_val();
            lam[i] = rnd_val();
            nd[i] = rnd_val();
        end
        send_word(k, r, a, lam, nd, fin);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    // extremes, load kinds, ignored kinds, open cases
    task automatic test_directed();
        logic signed [31:0] a[3], lam[3], nd[3];
        a = '{32'sh00010000, 32'sh00020000, -32'sh00030000};
        lam = '{32'sh00008000, -32'sh00010000, 32'sh00004000};
        nd = '{32'sh00001000, 32'sh00002000, 32'sh00003000};
        send_word(KIND_POINT, 0, a, lam, nd, 0);
        send_word(KIND_POINT, 0, a, lam, nd, 1);
        a = '{32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff};
        lam = '{32'sh80000000, 32'sh80000000, 32'sh80000000};
        nd = '{32'sh7fffffff, 32'sh80000000, 32'sh7fffffff};
        send_word(KIND_POINT, 0, a, lam, nd, 0);
        send_word(KIND_POINT, 0, a, lam, nd, 1);
        // out of range row and unused kind change nothing
        send_word(KIND_ROT, 3, a, lam, nd, 1);
        send_word(KIND_NONE, 3, a, lam, nd, 1);
        for (int r = 0; r < 3; r++)
        begin
            a = '{32'sh80000000, 32'sh7fffffff, -32'sh00010000};
            send_word(KIND_ROT, 2'(r), a, lam, nd, 0);
        end
        a = '{32'sh80000000, 32'sh7fffffff, 32'sh00050000};
        send_word(KIND_SHIFT, 0, a, lam, nd, 0);
        a = '{32'sh80000000, 32'sh80000000, 32'sh80000000};
        for (int n = 0; n < 4; n++)
            send_word(KIND_POINT, 0, a, lam, nd, 1'(n == 3));
        drain();
    endtask

    // mostly well formed sets: rotation, translation, then points
    task automatic test_random_sets(int items);
        int sent;
        int pts;
        sent = 0;
        while (sent < items)
        begin
            if ($urandom_range(0, 2) == 0)
            begin
                for (int r = 0; r < 3; r++)
                    send_random(KIND_ROT, 2'(r), 1'($urandom));
                sent += 3;
            end
            if ($urandom_range(0, 1) == 0)
            begin
                send_random(KIND_SHIFT, 2'($urandom), 1'($urandom));
                sent++;
            end
            pts = $urandom_range(1, 4);
            for (int p = 0; p < pts; p++)
            begin
                send_random(KIND_POINT, 2'($urandom), 1'(p == pts - 1));
                sent++;
            end
            // noise
            if ($urandom_range(0, 4) == 0)
                send_random(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                            1'($urandom));
        end
    endtask

    // sender holds off until all results are in
    task automatic test_hold_off();
        send_random(KIND_POINT, 0, 1);
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_words.size() != 0)
            @(posedge clk);
        send_random(KIND_POINT, 0, 0);
        send_random(KIND_POINT, 0, 1);
    endtask

    // receiver stall bursts, started at random and off while quiet
    always @(posedge clk)
    begin
        if (!rst_n || quiet)
        begin
            out_stall <= 1'b0;
            stall_left <= 0;
        end
        else if (stall_left > 1)
            stall_left <= stall_left - 1;
        else if (stall_left == 1)
        begin
            out_stall <= 1'b0;
            stall_left <= 0;
        end
        else if ($urandom_range(0, 5) == 0)
        begin
            out_stall <= 1'b1;
            stall_left <= $urandom_range(1, 5);
        end
    end

    // result checker
    always @(posedge clk)
    begin
        result_word_t got;
        result_word_t exp_w;
        if (rst_n && out_valid && !out_stall)
        begin
            got = '{result_kind, result_row, out_x, out_y, out_z, end_of_run};
            if (expected_words.size() == 0)
            begin
                failures++;
                $display("%0t unexpected word %h", $time, got);
            end
            else
            begin
                exp_w = expected_words.pop_front();
                if (got.rk !== exp_w.rk)
                    $display("%0t result_kind exp %0d got %0d", $time, exp_w.rk, got.rk);
                if (got.row !== exp_w.row)
                    $display("%0t result_row exp %0d got %0d", $time, exp_w.row, got.row);
                if (got.x !== exp_w.x)
                    $display("%0t out_x exp %h got %h", $time, exp_w.x, got.x);
                if (got.y !== exp_w.y)
                    $display("%0t out_y exp %h got %h", $time, exp_w.y, got.y);
                if (got.z !== exp_w.z)
                    $display("%0t out_z exp %h got %h", $time, exp_w.z, got.z);
                if (got.last !== exp_w.last)
                    $display("%0t end_of_run exp %0d got %0d", $time, exp_w.last,
                             got.last);
                if (got !== exp_w)
                    failures++;
            end
        end
    end

    // run limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        out_stall = 1'b0;
        stall_left = 0;
        kind = '0;
        row_index = '0;
        vec_a_x = '0; vec_a_y = '0; vec_a_z = '0;
        mult_x = '0; mult_y = '0; mult_z = '0;
        node_x = '0; node_y = '0; node_z = '0;
        final_point = 1'b0;
        failures = 0;
        cycles = 0;
        quiet = 1'b0;
        for (int i = 0; i < 9; i++)
        begin
            rot_m[i] = (i % 4 == 0) ? (64'sd1 <<< FB) : 0;
            stiff_sum[i] = 0;
        end
        for (int i = 0; i < 3; i++)
        begin
            shift_v[i] = 0;
            force_sum[i] = 0;
            moment_sum[i] = 0;
        end
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random_sets(110);
        test_hold_off();
        quiet = 1'b1;
        test_random_sets(35);
        drain();
        if (failures == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

/* filelist.f */
rtl/core/rcra_pkg.sv
rtl/core/rcra_mul.sv
rtl/core/rigid_contact_residual_assembly_core.sv
tb/sv/tb.sv
